// ----- design/blm_pkg.sv -----
`timescale 1ns / 1ps

package blm_pkg;

    localparam int SAMPLE_COUNT_DEF = 8;

    localparam int SAMPLE_W = 12;
    localparam int SUM_W    = 15;
    localparam int IDX_W    = 3;
    localparam int MV_W     = 14;
    localparam int PCT_W    = 7;
    localparam int RATIO_W  = 11;
    localparam int CFG_W    = 14;
    localparam int ADDR_W   = 3;
    localparam int QUO_W    = 21;
    localparam int CNT_W    = 5;
    localparam int IN_W     = 16;
    localparam int OUT_W    = 32;

    localparam logic [MV_W-1:0]    MV_MAX   = 14'd16383;
    localparam logic [PCT_W-1:0]   PCT_FULL = 7'd100;
    localparam logic [PCT_W-1:0]   PCT_ZERO = 7'd0;

    localparam logic [CNT_W-1:0]   PCT_STEPS_M1 = 5'(QUO_W - 1);

    localparam logic [RATIO_W-1:0] RATIO_RST      = 11'd512;
    localparam logic [MV_W-1:0]    EMPTY_RST      = 14'd3400;
    localparam logic [MV_W-1:0]    FULL_RST       = 14'd4150;
    localparam logic [MV_W-1:0]    DEEP_SLEEP_RST = 14'd3360;
    localparam logic [PCT_W-1:0]   LOW_PCT_RST    = 7'd5;

    localparam logic [ADDR_W-1:0] CFG_DIVIDER_RATIO = 3'd0;
    localparam logic [ADDR_W-1:0] CFG_EMPTY_MV      = 3'd1;
    localparam logic [ADDR_W-1:0] CFG_FULL_MV       = 3'd2;
    localparam logic [ADDR_W-1:0] CFG_DEEP_SLEEP_MV = 3'd3;
    localparam logic [ADDR_W-1:0] CFG_LOW_PERCENT   = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_AVG,
        ST_SCALE,
        ST_PREP,
        ST_PCT_DIV,
        ST_CAP,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic acc;
        logic avg;
        logic div_step;
        logic scale;
        logic prep;
        logic cap_raw;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic last;
        logic need_div;
        logic out_busy;
    } t_stat;

endpackage

// ----- design/blm_ctrl.sv -----
`timescale 1ns / 1ps

module blm_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  blm_pkg::t_stat i_stat,
    output blm_pkg::t_cmd  o_cmd,
    output logic          o_in_ready
);
    import blm_pkg::*;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.acc = 1'b1;
                    if (i_stat.last) begin
                        n_state = ST_AVG;
                    end
                end
            end
            ST_AVG: begin
                o_cmd.avg = 1'b1;
                n_state   = ST_SCALE;
            end
            ST_SCALE: begin
                o_cmd.scale = 1'b1;
                n_state     = ST_PREP;
            end
            ST_PREP: begin
                o_cmd.prep = 1'b1;
                if (i_stat.need_div) begin
                    n_state = ST_PCT_DIV;
                    n_cnt   = PCT_STEPS_M1;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_PCT_DIV: begin
                o_cmd.div_step = 1'b1;
                if (r_cnt == '0) begin
                    n_state = ST_CAP;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            ST_CAP: begin
                o_cmd.cap_raw = 1'b1;
                n_state       = ST_DONE;
            end
            ST_DONE: begin
                if (!i_stat.out_busy) begin
                    o_cmd.finish = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- design/blm_datapath.sv -----
`timescale 1ns / 1ps

module blm_datapath #(
    parameter int SAMPLE_COUNT = blm_pkg::SAMPLE_COUNT_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [blm_pkg::ADDR_W-1:0] i_cfg_addr,
    input  logic [blm_pkg::CFG_W-1:0]  i_cfg_wdata,
    input  logic [blm_pkg::SAMPLE_W-1:0] i_sample_mv,
    input  logic                      i_usb_present,
    input  blm_pkg::t_cmd              i_cmd,
    output blm_pkg::t_stat             o_stat,
    input  logic                      i_out_ready,
    output logic                      o_out_valid,
    output logic [blm_pkg::MV_W-1:0]  o_battery_mv,
    output logic [blm_pkg::PCT_W-1:0] o_raw_percent,
    output logic [blm_pkg::PCT_W-1:0] o_shown_percent,
    output logic                      o_low_battery,
    output logic                      o_deep_sleep
);
    import blm_pkg::*;

    localparam logic [IDX_W-1:0] CNT_MOD    = IDX_W'(SAMPLE_COUNT);
    localparam int               AVG_SH     = SUM_W + IDX_W;
    localparam int               RECIP_W    = AVG_SH + 1;
    localparam int               AVG_PROD_W = SUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] AVG_RECIP =
        RECIP_W'(((1 << AVG_SH) + SAMPLE_COUNT - 1) / SAMPLE_COUNT);
    localparam int               PROD_W     = SAMPLE_W + RATIO_W;

    logic [RATIO_W-1:0] r_ratio;
    logic [MV_W-1:0]    r_empty, r_full, r_deep;
    logic [PCT_W-1:0]   r_low_pct;

    logic [SUM_W-1:0]   r_sum;
    logic [IDX_W-1:0]   r_idx;
    logic               r_usb;
    logic [QUO_W-1:0]   r_quo;
    logic [MV_W-1:0]    r_rem;
    logic [MV_W-1:0]    r_den;
    logic [MV_W-1:0]    r_mv;
    logic [PCT_W-1:0]   r_raw;
    logic [PCT_W-1:0]   r_disp;
    logic               r_disp_valid;

    logic               r_out_valid;
    logic [MV_W-1:0]    r_out_mv;
    logic [PCT_W-1:0]   r_out_raw, r_out_shown;
    logic               r_out_low, r_out_deep;

    logic [SUM_W-1:0]   w_sum_next;
    logic [IDX_W-1:0]   w_idx_next;
    logic [MV_W:0]      w_rem_sh, w_rem_sub;
    logic               w_ge;
    logic [AVG_PROD_W-1:0] w_avg_prod;
    logic [PROD_W-1:0]  w_prod;
    logic [SUM_W-1:0]   w_scaled;
    logic [MV_W-1:0]    w_mv_sat;
    logic [QUO_W-1:0]   w_pct_num;
    logic               w_above_empty, w_below_full;
    logic [PCT_W-1:0]   w_disp_next;

    assign w_sum_next = r_sum + SUM_W'(i_sample_mv);
    assign w_idx_next = r_idx + 1'b1;

    assign w_rem_sh  = {r_rem, r_quo[QUO_W-1]};
    assign w_ge      = (w_rem_sh >= {1'b0, r_den});
    assign w_rem_sub = w_rem_sh - {1'b0, r_den};

    assign w_avg_prod = AVG_PROD_W'(r_quo[SUM_W-1:0]) * AVG_PROD_W'(AVG_RECIP);

    assign w_prod   = PROD_W'(r_quo[SAMPLE_W-1:0]) * PROD_W'(r_ratio);
    assign w_scaled = w_prod[PROD_W-1:8];
    assign w_mv_sat = (w_scaled > SUM_W'(MV_MAX)) ? MV_MAX : w_scaled[MV_W-1:0];

    assign w_above_empty = (r_mv > r_empty);
    assign w_below_full  = (r_mv < r_full);
    assign w_pct_num     = QUO_W'(r_mv - r_empty) * QUO_W'(PCT_FULL);

    always_comb begin
        if (!r_disp_valid) begin
            w_disp_next = r_raw;
        end else if (r_usb) begin
            w_disp_next = (r_raw > r_disp) ? r_raw : r_disp;
        end else begin
            w_disp_next = (r_raw < r_disp) ? r_raw : r_disp;
        end
    end

    assign o_stat.last     = (w_idx_next == CNT_MOD);
    assign o_stat.need_div = w_above_empty && w_below_full;
    assign o_stat.out_busy = r_out_valid && !i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ratio   <= RATIO_RST;
            r_empty   <= EMPTY_RST;
            r_full    <= FULL_RST;
            r_deep    <= DEEP_SLEEP_RST;
            r_low_pct <= LOW_PCT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_DIVIDER_RATIO: r_ratio   <= i_cfg_wdata[RATIO_W-1:0];
                CFG_EMPTY_MV:      r_empty   <= i_cfg_wdata[MV_W-1:0];
                CFG_FULL_MV:       r_full    <= i_cfg_wdata[MV_W-1:0];
                CFG_DEEP_SLEEP_MV: r_deep    <= i_cfg_wdata[MV_W-1:0];
                CFG_LOW_PERCENT:   r_low_pct <= i_cfg_wdata[PCT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum        <= '0;
            r_idx        <= '0;
            r_disp       <= '0;
            r_disp_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.acc) begin
                if (o_stat.last) begin
                    r_sum <= '0;
                    r_idx <= '0;
                end else begin
                    r_sum <= w_sum_next;
                    r_idx <= w_idx_next;
                end
            end
            if (i_cmd.finish) begin
                r_disp       <= w_disp_next;
                r_disp_valid <= 1'b1;
                r_out_valid  <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.acc && o_stat.last) begin
            r_usb <= i_usb_present;
            r_quo <= QUO_W'(w_sum_next);
        end
        if (i_cmd.avg) begin
            r_quo <= QUO_W'(w_avg_prod[AVG_SH+SAMPLE_W-1:AVG_SH]);
        end
        if (i_cmd.div_step) begin
            r_quo <= {r_quo[QUO_W-2:0], w_ge};
            r_rem <= w_ge ? w_rem_sub[MV_W-1:0] : w_rem_sh[MV_W-1:0];
        end
        if (i_cmd.scale) begin
            r_mv <= w_mv_sat;
        end
        if (i_cmd.prep) begin
            r_raw <= w_above_empty ? PCT_FULL : PCT_ZERO;
            r_quo <= w_pct_num;
            r_rem <= '0;
            r_den <= r_full - r_empty;
        end
        if (i_cmd.cap_raw) begin
            r_raw <= r_quo[PCT_W-1:0];
        end
        if (i_cmd.finish) begin
            r_out_mv    <= r_mv;
            r_out_raw   <= r_raw;
            r_out_shown <= w_disp_next;
            r_out_low   <= !r_usb && (w_disp_next <= r_low_pct);
            r_out_deep  <= !r_usb && (r_mv <= r_deep);
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_battery_mv    = r_out_mv;
    assign o_raw_percent   = r_out_raw;
    assign o_shown_percent = r_out_shown;
    assign o_low_battery   = r_out_low;
    assign o_deep_sleep    = r_out_deep;

endmodule

// ----- design/battery_level_monitor_unit.sv -----
// A sample that does not close a batch is accepted in IDLE and gives no item; a
// batch-closing sample passes through AVG, SCALE and PREP and, when the voltage is inside
// the empty..full span, also through PCT_DIV and CAP; DONE issues its item once the output
// is not stalled. A reciprocal multiply forms the average, a 21-step divider the percent.
// Throughput: one sample per cycle between batch ends; the output register holds an item.
// Reset: synchronous, active low; restores register defaults and clears batch and display.
`timescale 1ns / 1ps

module battery_level_monitor_unit #(
    parameter int SAMPLE_COUNT = blm_pkg::SAMPLE_COUNT_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [blm_pkg::ADDR_W-1:0] i_cfg_addr,
    input  logic [blm_pkg::CFG_W-1:0]  i_cfg_wdata,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    // [11:0] sample_mv, [12] usb_present, [15:13] zero
    input  logic [blm_pkg::IN_W-1:0]   s_axis_tdata,
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    // [13:0] battery_mv, [20:14] raw_percent, [27:21] shown_percent,
    // [28] low_battery, [29] deep_sleep, [31:30] zero
    output logic [blm_pkg::OUT_W-1:0]  m_axis_tdata
);
    import blm_pkg::*;

    t_cmd             w_cmd;
    t_stat            w_stat;
    logic [MV_W-1:0]  w_mv;
    logic [PCT_W-1:0] w_raw, w_shown;
    logic             w_low, w_deep;

    blm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd),
        .o_in_ready (s_axis_tready)
    );

    blm_datapath #(
        .SAMPLE_COUNT (SAMPLE_COUNT)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_sample_mv     (s_axis_tdata[SAMPLE_W-1:0]),
        .i_usb_present   (s_axis_tdata[SAMPLE_W]),
        .i_cmd           (w_cmd),
        .o_stat          (w_stat),
        .i_out_ready     (m_axis_tready),
        .o_out_valid     (m_axis_tvalid),
        .o_battery_mv    (w_mv),
        .o_raw_percent   (w_raw),
        .o_shown_percent (w_shown),
        .o_low_battery   (w_low),
        .o_deep_sleep    (w_deep)
    );

    assign m_axis_tdata = {2'b00, w_deep, w_low, w_shown, w_raw, w_mv};

endmodule

// ----- design/blm_checker.sv -----
`timescale 1ns / 1ps

module blm_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       s_axis_tvalid,
    input logic                       s_axis_tready,
    input logic                       m_axis_tvalid,
    input logic                       m_axis_tready,
    input logic [blm_pkg::OUT_W-1:0]  m_axis_tdata
);
    import blm_pkg::*;

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output item valid right after reset");

    a_out_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled output item changed");

    a_raw_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[20:14] <= PCT_FULL)
        else $error("raw percent above full scale");

    a_shown_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[27:21] <= PCT_FULL && m_axis_tdata[31:30] == 2'b00)
        else $error("shown percent above full scale or padding set");

    a_busy_after_batch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !$past(m_axis_tvalid) |-> !$past(s_axis_tready, 1) ||
        !$past(s_axis_tvalid, 1))
        else $error("new item appeared while input was being accepted");

endmodule

bind battery_level_monitor_unit blm_checker u_blm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
